// ===== src/assert_macros.svh =====
// Assertion macros shared by the display update arbiter RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define DUA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("display update arbiter: implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define DUA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("display update arbiter: next-cycle check failed");

`endif

// ===== src/dua_pkg.sv =====
// Package for the display update arbiter: widths, constants, register
// indexes and the structs passed between modules. No dependencies.
package dua_pkg;

	localparam int TICK_WIDTH = 32;
	localparam int TEXT_WIDTH = 8;
	localparam int VALUE_WIDTH = 32;
	localparam int THRESH_WIDTH = 31;
	localparam int LINGER_WIDTH = 16;
	localparam int MODE_WIDTH = 5;
	localparam int FONT_WIDTH = 2;
	localparam int TIER_WIDTH = 2;
	localparam int CFG_IDX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH = THRESH_WIDTH;

	localparam logic [TIER_WIDTH-1:0] OWN_TIER = 2'd3;
	localparam logic [MODE_WIDTH-1:0] MODE_MAX = 5'd18;
	localparam logic [FONT_WIDTH-1:0] FONT_MAX = 2'd3;
	// about 0.0005 in Q16.16
	localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 31'd33;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_CHANGE_THRESHOLD = 3'd0,
		REG_LINGER_TICKS = 3'd1,
		REG_NUMBER_MODE = 3'd2,
		REG_FONT_SIZE = 3'd3,
		REG_TEXT_PATCHED = 3'd4,
		REG_VALUE_PATCHED = 3'd5,
		REG_TRIGGER_PATCHED = 3'd6,
		REG_SELECT_USED = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [THRESH_WIDTH-1:0] change_threshold;
		logic [LINGER_WIDTH-1:0] linger_ticks;
		logic [MODE_WIDTH-1:0] number_mode;
		logic [FONT_WIDTH-1:0] font_size;
		logic text_patched;
		logic value_patched;
		logic trigger_patched;
		logic select_used;
	} cfg_t;

	typedef struct packed {
		logic req_type;
		logic selected;
		logic [TEXT_WIDTH-1:0] text_number;
		logic [TEXT_WIDTH-1:0] header_number;
		logic signed [VALUE_WIDTH-1:0] sample_value;
		logic trigger_high;
		logic use_default;
		logic [TIER_WIDTH-1:0] foreign_tier;
		logic [LINGER_WIDTH-1:0] foreign_linger;
	} item_t;

	typedef struct packed {
		logic [TICK_WIDTH-1:0] tick_count;
		logic [TICK_WIDTH-1:0] linger_until;
		logic [TICK_WIDTH-1:0] last_write_tick;
		logic owner_here;
		logic [TIER_WIDTH-1:0] owner_tier;
		logic active_flag;
		logic [TEXT_WIDTH-1:0] header;
		logic is_text;
		logic [TEXT_WIDTH-1:0] body_text;
		logic signed [VALUE_WIDTH-1:0] body_value;
		logic [MODE_WIDTH-1:0] mode;
		logic [FONT_WIDTH-1:0] font;
		logic prev_selected;
		logic prev_trigger;
		logic [TEXT_WIDTH-1:0] last_text;
		logic signed [VALUE_WIDTH-1:0] last_value;
	} state_t;

	typedef struct packed {
		logic screen_active;
		logic owned_here;
		logic shows_text;
		logic [TEXT_WIDTH-1:0] shown_header;
		logic [TEXT_WIDTH-1:0] shown_text;
		logic signed [VALUE_WIDTH-1:0] shown_value;
		logic [MODE_WIDTH-1:0] shown_mode;
		logic [FONT_WIDTH-1:0] shown_font;
		logic write_accepted;
	} result_t;

endpackage

// ===== src/dua_cfg_regs.sv =====
// Configuration register file of the display update arbiter.
// Depends on dua_pkg.
module dua_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [dua_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [dua_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
	output dua_pkg::cfg_t cfg
);

	dua_pkg::cfg_t cfg_q;

	// Write decode; all registers reset to their documented values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{change_threshold: dua_pkg::THRESH_RESET, default: '0};
		end else if (cfg_we) begin
			case (dua_pkg::cfg_reg_t'(cfg_index))
				dua_pkg::REG_CHANGE_THRESHOLD: begin
					cfg_q.change_threshold <= cfg_wdata[dua_pkg::THRESH_WIDTH-1:0];
				end
				dua_pkg::REG_LINGER_TICKS: begin
					cfg_q.linger_ticks <= cfg_wdata[dua_pkg::LINGER_WIDTH-1:0];
				end
				dua_pkg::REG_NUMBER_MODE: begin
					cfg_q.number_mode <= cfg_wdata[dua_pkg::MODE_WIDTH-1:0];
				end
				dua_pkg::REG_FONT_SIZE: begin
					cfg_q.font_size <= cfg_wdata[dua_pkg::FONT_WIDTH-1:0];
				end
				dua_pkg::REG_TEXT_PATCHED: begin
					cfg_q.text_patched <= cfg_wdata[0];
				end
				dua_pkg::REG_VALUE_PATCHED: begin
					cfg_q.value_patched <= cfg_wdata[0];
				end
				dua_pkg::REG_TRIGGER_PATCHED: begin
					cfg_q.trigger_patched <= cfg_wdata[0];
				end
				dua_pkg::REG_SELECT_USED: begin
					cfg_q.select_used <= cfg_wdata[0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/dua_eval.sv =====
// Single-pass evaluation of one item against the arbiter state: next state
// and the result item. Purely combinational. Depends on dua_pkg.
module dua_eval (
	input  dua_pkg::cfg_t cfg,
	input  dua_pkg::item_t item,
	input  dua_pkg::state_t st,
	output dua_pkg::state_t st_next,
	output dua_pkg::result_t res
);

	logic just_sel;
	logic deselected;
	logic edge_seen;
	logic have;
	logic attempt;
	logic linger_over;
	logic ok;
	logic accepted;
	logic [dua_pkg::TEXT_WIDTH-1:0] body;
	logic signed [dua_pkg::VALUE_WIDTH-1:0] val;
	logic signed [dua_pkg::VALUE_WIDTH:0] diff;
	logic [dua_pkg::VALUE_WIDTH:0] mag;
	logic big_move;

	// Gate, edge and content decode
	always_comb begin
		just_sel = cfg.select_used && item.selected && !st.prev_selected;
		deselected = cfg.select_used && !item.selected;
		edge_seen = item.trigger_high && !st.prev_trigger;
		linger_over = st.tick_count >= st.linger_until;
		body = cfg.text_patched ? item.text_number : '0;
		val = cfg.text_patched ? '0 : item.sample_value;
		have = cfg.text_patched ? (item.text_number != '0) : cfg.value_patched;
	end

	// Distance of the new value from the last one shown
	always_comb begin
		diff = {val[dua_pkg::VALUE_WIDTH-1], val}
			- {st.last_value[dua_pkg::VALUE_WIDTH-1], st.last_value};
		mag = diff[dua_pkg::VALUE_WIDTH] ? (~diff + 1'b1) : diff;
		big_move = mag > {{(dua_pkg::VALUE_WIDTH + 1 - dua_pkg::THRESH_WIDTH){1'b0}},
			cfg.change_threshold};
	end

	// Attempt and arbitration
	always_comb begin
		attempt = 1'b0;
		if (have && !deselected) begin
			if (cfg.trigger_patched) begin
				attempt = edge_seen;
			end else if (just_sel) begin
				attempt = 1'b1;
			end else if (cfg.text_patched) begin
				attempt = body != st.last_text;
			end else begin
				attempt = big_move;
			end
			if (item.use_default && linger_over && !st.owner_here) begin
				attempt = 1'b1;
			end
		end
		ok = st.owner_here || linger_over
			|| (st.active_flag && st.last_write_tick == st.tick_count
			&& dua_pkg::OWN_TIER >= st.owner_tier);
		accepted = !item.req_type && attempt && ok;
	end

	// Next state
	always_comb begin
		st_next = st;
		if (item.req_type) begin
			// another writer took the screen this tick
			st_next.active_flag = 1'b1;
			st_next.owner_here = 1'b0;
			st_next.owner_tier = item.foreign_tier;
			st_next.linger_until = st.tick_count
				+ {{(dua_pkg::TICK_WIDTH - dua_pkg::LINGER_WIDTH){1'b0}}, item.foreign_linger};
			st_next.last_write_tick = st.tick_count;
		end else begin
			st_next.tick_count = st.tick_count + 1'b1;
			st_next.prev_selected = item.selected;
			st_next.prev_trigger = item.trigger_high;
			if (accepted) begin
				st_next.active_flag = 1'b1;
				st_next.header = item.header_number;
				st_next.is_text = cfg.text_patched;
				if (cfg.text_patched) begin
					st_next.body_text = body;
				end else begin
					st_next.body_value = val;
				end
				st_next.mode = (cfg.number_mode > dua_pkg::MODE_MAX)
					? dua_pkg::MODE_MAX : cfg.number_mode;
				st_next.font = (cfg.font_size > dua_pkg::FONT_MAX)
					? dua_pkg::FONT_MAX : cfg.font_size;
				st_next.owner_here = 1'b1;
				st_next.owner_tier = dua_pkg::OWN_TIER;
				st_next.linger_until = st.tick_count
					+ {{(dua_pkg::TICK_WIDTH - dua_pkg::LINGER_WIDTH){1'b0}}, cfg.linger_ticks};
				st_next.last_write_tick = st.tick_count;
				st_next.last_value = val;
				st_next.last_text = body;
			end
			// empty text clears the text baseline
			if (!deselected && cfg.text_patched && !have) begin
				st_next.last_text = '0;
			end
		end
	end

	// Result reflects the state after the item
	always_comb begin
		res.screen_active = st_next.active_flag;
		res.owned_here = st_next.owner_here;
		res.shows_text = st_next.is_text;
		res.shown_header = st_next.header;
		res.shown_text = st_next.body_text;
		res.shown_value = st_next.body_value;
		res.shown_mode = st_next.mode;
		res.shown_font = st_next.font;
		res.write_accepted = accepted;
	end

endmodule

// ===== src/display_update_arbiter.sv =====
// Display update arbiter top level: input register, state and result register.
// Depends on dua_pkg, dua_cfg_regs, dua_eval and assert_macros.svh.
//
// One item per clock while the output does not stall. An accepted item is
// registered in the input register, evaluated there against the arbiter
// state, and its result is registered in the result register, which drives
// the output. The rate is set by the state update: every item reads the state
// the previous item left, written back as that item moves to the result
// register. A stall on the output holds the result register and then the
// input register; input stall rises only when both are occupied. The user
// writes configuration through cfg_we, cfg_index and cfg_wdata only while no
// item is in flight; the block does not enforce this. Writes are registered.
`include "assert_macros.svh"

module display_update_arbiter (
	input  logic clk,
	input  logic arst_n,
	// configuration
	input  logic cfg_we,
	input  logic [dua_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [dua_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
	// input channel
	input  logic in_valid,
	output logic in_stall,
	input  logic req_type,
	input  logic selected,
	input  logic [dua_pkg::TEXT_WIDTH-1:0] text_number,
	input  logic [dua_pkg::TEXT_WIDTH-1:0] header_number,
	input  logic signed [dua_pkg::VALUE_WIDTH-1:0] sample_value,
	input  logic trigger_high,
	input  logic use_default,
	input  logic [dua_pkg::TIER_WIDTH-1:0] foreign_tier,
	input  logic [dua_pkg::LINGER_WIDTH-1:0] foreign_linger,
	// output channel
	output logic out_valid,
	input  logic out_stall,
	output logic screen_active,
	output logic owned_here,
	output logic shows_text,
	output logic [dua_pkg::TEXT_WIDTH-1:0] shown_header,
	output logic [dua_pkg::TEXT_WIDTH-1:0] shown_text,
	output logic signed [dua_pkg::VALUE_WIDTH-1:0] shown_value,
	output logic [dua_pkg::MODE_WIDTH-1:0] shown_mode,
	output logic [dua_pkg::FONT_WIDTH-1:0] shown_font,
	output logic write_accepted
);

	dua_pkg::cfg_t cfg;
	dua_pkg::item_t item_in;
	dua_pkg::item_t item_s1;
	logic valid_s1;
	dua_pkg::state_t st_q;
	dua_pkg::state_t st_next;
	dua_pkg::result_t res_next;
	dua_pkg::result_t res_s2;
	logic valid_s2;
	logic advance;
	logic in_take;

	dua_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Pack the input fields
	always_comb begin
		item_in.req_type = req_type;
		item_in.selected = selected;
		item_in.text_number = text_number;
		item_in.header_number = header_number;
		item_in.sample_value = sample_value;
		item_in.trigger_high = trigger_high;
		item_in.use_default = use_default;
		item_in.foreign_tier = foreign_tier;
		item_in.foreign_linger = foreign_linger;
	end

	// Flow control: stage 1 moves on when the result register is free or drains
	assign advance = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= item_in;
		end
	end

	dua_eval u_eval (
		.cfg     (cfg),
		.item    (item_s1),
		.st      (st_q),
		.st_next (st_next),
		.res     (res_next)
	);

	// Arbiter state, updated once per evaluated item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid = valid_s2;
	assign screen_active = res_s2.screen_active;
	assign owned_here = res_s2.owned_here;
	assign shows_text = res_s2.shows_text;
	assign shown_header = res_s2.shown_header;
	assign shown_text = res_s2.shown_text;
	assign shown_value = res_s2.shown_value;
	assign shown_mode = res_s2.shown_mode;
	assign shown_font = res_s2.shown_font;
	assign write_accepted = res_s2.write_accepted;

	// A foreign item always leaves the screen owned elsewhere, with no write
	`DUA_ASSERT_NXT(a_foreign_releases, clk, arst_n, advance && item_s1.req_type, valid_s2 && !res_s2.owned_here && !res_s2.write_accepted)
	// An accepted write means this writer owns an active screen
	`DUA_ASSERT_IMP(a_write_owns, clk, arst_n, valid_s2 && res_s2.write_accepted, res_s2.owned_here && res_s2.screen_active)
	// Only own evaluations advance the tick
	`DUA_ASSERT_NXT(a_tick_step, clk, arst_n, advance && !item_s1.req_type, st_q.tick_count == $past(st_q.tick_count) + 1'b1)
	// Input is held off only while the result register is blocked
	`DUA_ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, valid_s1 && valid_s2 && out_stall)

endmodule
